[design/roti_sliding_index_unit_defines.svh]
// ----------------------------------------------------------------------------
// ROTI sliding index unit: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ROTI_SLIDING_INDEX_UNIT_DEFINES_SVH
`define ROTI_SLIDING_INDEX_UNIT_DEFINES_SVH

// Same-cycle implication.
`define ROTI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ROTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/roti_pkg.sv]
// ----------------------------------------------------------------------------
// ROTI package
// Widths, reset values, register codes and the root unit's control types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package roti_pkg;

  localparam int DEF_MAX_SATS   = 64;
  localparam int DEF_MAX_WINDOW = 32;

  localparam int SLOT_W   = 6;
  localparam int PHASE_W  = 48;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int WLEN_W   = 6;
  localparam int ROT_W    = 24;
  localparam int ROTI_W   = 23;
  localparam int DIVISOR_W = 9;
  localparam int RADICAND_W = 64;

  localparam logic [CFG_W-1:0]        WL_A_RESET      = 32'd817305097;
  localparam logic [CFG_W-1:0]        WL_B_RESET      = 32'd1048874879;
  localparam logic signed [CFG_W-1:0] ROT_SCALE_RESET = -32'sd1247770;
  localparam logic [WLEN_W-1:0]       WLEN_RESET      = 6'd10;
  localparam logic [ROTI_W-1:0]       ROTI_CAP        = 23'h7FFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAVELENGTH_A,
    CFG_WAVELENGTH_B,
    CFG_ROT_SCALE,
    CFG_WINDOW_LENGTH
  } cfg_index_t;

  typedef struct packed {
    logic                 go;
    logic [DIVISOR_W-1:0] divisor;
  } sq_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sq_stat_t;

endpackage

[design/roti_isqrt_div.sv]
// ----------------------------------------------------------------------------
// ROTI root and divide unit
// Integer square root one bit per cycle, then restoring division of the root
// by the window length one bit per cycle, saturated to the ROTI range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module roti_isqrt_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  roti_pkg::sq_req_t                 req,
  input  logic [roti_pkg::RADICAND_W-1:0]   radicand,
  output roti_pkg::sq_stat_t                stat,
  output logic [roti_pkg::ROTI_W-1:0]       roti
);
  import roti_pkg::*;

  typedef enum logic [1:0] {SQ_IDLE, SQ_ROOT, SQ_DIV} sq_state_t;

  sq_state_t              state_r;
  logic [4:0]             cnt_r;
  logic [63:0]            rem_r;
  logic [63:0]            root_r;
  logic [63:0]            bit_r;
  logic [DIVISOR_W-1:0]   divisor_r;
  logic [DIVISOR_W-1:0]   dr_r;
  logic [31:0]            quo_r;
  logic                   done_r;
  logic [ROTI_W-1:0]      roti_r;

  logic [63:0]            trial;
  logic                   root_ge;
  logic [DIVISOR_W:0]     dtrial;
  logic                   div_ge;
  logic [31:0]            quo_fin;

  assign trial   = root_r + bit_r;
  assign root_ge = rem_r >= trial;
  assign dtrial  = {dr_r, root_r[31]};
  assign div_ge  = dtrial >= {1'b0, divisor_r};
  assign quo_fin = {quo_r[30:0], div_ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == SQ_DIV) && (cnt_r == 5'd31);
      case (state_r)
        SQ_IDLE: begin
          if (req.go) begin
            rem_r     <= radicand;
            root_r    <= '0;
            bit_r     <= 64'h4000_0000_0000_0000;
            divisor_r <= req.divisor;
            dr_r      <= '0;
            quo_r     <= '0;
            cnt_r     <= '0;
            state_r   <= SQ_ROOT;
          end
        end
        SQ_ROOT: begin
          if (root_ge) begin
            rem_r  <= rem_r - trial;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            state_r <= SQ_DIV;
          end
        end
        SQ_DIV: begin
          // The root is below 2^32; its bits are shifted out of bit 31.
          dr_r   <= div_ge ? DIVISOR_W'(dtrial - {1'b0, divisor_r}) : DIVISOR_W'(dtrial);
          quo_r  <= quo_fin;
          root_r <= root_r << 1;
          cnt_r  <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            roti_r  <= (quo_fin > 32'(ROTI_CAP)) ? ROTI_CAP : quo_fin[ROTI_W-1:0];
            state_r <= SQ_IDLE;
          end
        end
        default: state_r <= SQ_IDLE;
      endcase
    end
  end

  assign stat.busy = (state_r != SQ_IDLE);
  assign stat.done = done_r;
  assign roti      = roti_r;

endmodule

[design/roti_sliding_index_unit.sv]
// ----------------------------------------------------------------------------
// ROTI sliding index unit
// Per-satellite geometry-free combination, rate of TEC and its windowed
// standard deviation, with per-slot state and the ROT rings in memories.
//
//   channel  dir  handshake          payload
//   cfg      in   cfg_we             cfg_index, cfg_data
//   in       in   in_valid/in_stall  in_sat_slot, in_phase_a, in_phase_b
//   out      out  out_valid/out_stall out_slot_echo, out_rot_*, out_roti_*
//
// An item in range, with N the window length, passes through the shared
// multiplier for the combination and ROT, a ring walk over N entries, the
// sums and, when the window is full, the root and divide unit. A slot out of
// range goes straight to the output state. After reset a clearing pass over
// all MAX_SATS * MAX_WINDOW ring entries zeroes the memories while no item is
// taken. A held result does not block the next item; only the final load
// waits for the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "roti_sliding_index_unit_defines.svh"

module roti_sliding_index_unit #(
  parameter int MAX_SATS   = roti_pkg::DEF_MAX_SATS,
  parameter int MAX_WINDOW = roti_pkg::DEF_MAX_WINDOW
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [roti_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [roti_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [roti_pkg::SLOT_W-1:0]         in_sat_slot,
  input  logic signed [roti_pkg::PHASE_W-1:0] in_phase_a,
  input  logic signed [roti_pkg::PHASE_W-1:0] in_phase_b,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [roti_pkg::SLOT_W-1:0]         out_slot_echo,
  output logic signed [roti_pkg::ROT_W-1:0]   out_rot_value,
  output logic                                out_rot_ok,
  output logic [roti_pkg::ROTI_W-1:0]         out_roti_value,
  output logic                                out_roti_ok
);
  import roti_pkg::*;

  localparam int SLOT_AW    = (MAX_SATS > 1) ? $clog2(MAX_SATS) : 1;
  localparam int POS_W      = $clog2(MAX_WINDOW);
  localparam int RUN_W      = $clog2(MAX_WINDOW + 1);
  localparam int AUX_W      = 1 + POS_W + RUN_W;
  localparam int RING_DEPTH = MAX_SATS * MAX_WINDOW;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam logic [POS_W-1:0]   POS_LAST = POS_W'(MAX_WINDOW - 1);
  localparam logic [RUN_W-1:0]   RUN_MAX  = RUN_W'(MAX_WINDOW);
  localparam logic [RING_AW-1:0] CLR_LAST = RING_AW'(RING_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_CALC, ST_WIN, ST_TOT, ST_SQ, ST_OUT
  } state_t;

  // Configuration.
  logic [CFG_W-1:0]        wl_a_r;
  logic [CFG_W-1:0]        wl_b_r;
  logic signed [CFG_W-1:0] scale_r;
  logic [WLEN_W-1:0]       wlen_r;
  logic [RUN_W-1:0]        n_eff;

  // Control.
  state_t               state_r;
  logic [RING_AW-1:0]   clr_cnt_r;
  logic [3:0]           step_r;
  logic [RUN_W-1:0]     e_r;
  logic                 pend_r;

  // Item and datapath.
  logic [SLOT_W-1:0]         slot_r;
  logic [SLOT_AW-1:0]        slot_idx;
  logic signed [PHASE_W-1:0] pa_r;
  logic signed [PHASE_W-1:0] pb_r;
  logic                      have_r;
  logic signed [63:0]        comb_r;
  logic signed [63:0]        diff_r;
  logic [95:0]               sp_r;
  logic signed [ROT_W-1:0]   rot_r;
  logic                      rot_ok_r;
  logic                      roti_ok_r;
  logic [ROTI_W-1:0]         roti_r;
  logic [POS_W-1:0]          rd_idx_r;
  logic signed [32:0]        acc_sum_r;
  logic [55:0]               acc_sq_r;
  logic [63:0]               sq2_r;
  logic [63:0]               tot_r;
  logic [63:0]               v_r;
  logic signed [33:0]        mul_a;
  logic signed [33:0]        mul_b;
  logic signed [67:0]        prod_r;

  // Output register.
  logic                      out_valid_r;
  logic [SLOT_W-1:0]         out_slot_r;
  logic signed [ROT_W-1:0]   out_rot_r;
  logic                      out_rot_ok_r;
  logic [ROTI_W-1:0]         out_roti_r;
  logic                      out_roti_ok_r;

  // Memories.
  logic signed [63:0]  comb_mem [MAX_SATS];
  logic [AUX_W-1:0]    aux_mem  [MAX_SATS];
  logic signed [ROT_W-1:0] ring_mem [RING_DEPTH];
  logic signed [63:0]  comb_q_r;
  logic [AUX_W-1:0]    aux_q_r;
  logic signed [ROT_W-1:0] ring_q_r;
  logic [SLOT_AW-1:0]  sm_raddr;
  logic                sm_we;
  logic [SLOT_AW-1:0]  sm_waddr;
  logic signed [63:0]  comb_wdata;
  logic [AUX_W-1:0]    aux_wdata;
  logic                ring_we;
  logic [RING_AW-1:0]  ring_waddr;
  logic signed [ROT_W-1:0] ring_wdata;
  logic [RING_AW-1:0]  ring_raddr;

  // Combinational helpers.
  logic                    prev_present;
  logic [POS_W-1:0]        pos_q;
  logic [RUN_W-1:0]        run_q;
  logic [POS_W-1:0]        pos_inc;
  logic [POS_W-1:0]        rd_dec;
  logic signed [23:0]      hs_a;
  logic signed [23:0]      hs_b;
  logic [63:0]             dmag;
  logic [31:0]             smag;
  logic                    neg;
  logic [95:0]             sp_rnd;
  logic [67:0]             rot_mag;
  logic signed [ROT_W-1:0] rot_sat;
  logic                    rot_ok_c;
  logic signed [ROT_W-1:0] rot_fin;
  logic [RUN_W-1:0]        run_nxt;
  logic signed [ROT_W-1:0] x_win;
  logic [32:0]             sum_mag;
  logic                    in_range;
  sq_req_t                 sq_req;
  sq_stat_t                sq_stat;
  logic [ROTI_W-1:0]       sq_roti;

  always_comb begin
    if (wlen_r < 6'd2) begin
      n_eff = RUN_W'(2);
    end else if (32'(wlen_r) > MAX_WINDOW) begin
      n_eff = RUN_MAX;
    end else begin
      n_eff = RUN_W'(wlen_r);
    end
  end

  assign slot_idx     = SLOT_AW'(slot_r);
  assign in_range     = 32'(in_sat_slot) < MAX_SATS;
  assign prev_present = aux_q_r[AUX_W-1];
  assign pos_q        = aux_q_r[AUX_W-2:RUN_W];
  assign run_q        = aux_q_r[RUN_W-1:0];
  assign pos_inc      = (pos_q == POS_LAST) ? '0 : pos_q + POS_W'(1);
  assign rd_dec       = (rd_idx_r == '0) ? POS_LAST : rd_idx_r - POS_W'(1);
  assign hs_a         = pa_r[47:24];
  assign hs_b         = pb_r[47:24];
  assign dmag         = diff_r[63] ? 64'(64'sd0 - diff_r) : 64'(diff_r);
  assign smag         = scale_r[31] ? 32'(32'sd0 - scale_r) : 32'(scale_r);
  assign neg          = diff_r[63] ^ scale_r[31];
  assign x_win        = (e_r == '0) ? rot_r : ring_q_r;
  assign sum_mag      = acc_sum_r[32] ? 33'(33'sd0 - acc_sum_r) : 33'(acc_sum_r);

  // Rounded magnitude, ties away from zero, then saturation with the sign.
  assign sp_rnd  = sp_r + 96'(1 << 27);
  assign rot_mag = sp_rnd[95:28];
  always_comb begin
    if (neg) begin
      rot_sat = (rot_mag >= 68'd8388608) ? -24'sd8388608
                                         : ROT_W'(24'sd0 - signed'(24'(rot_mag)));
    end else begin
      rot_sat = (rot_mag >= 68'd8388607) ? 24'sd8388607 : signed'(24'(rot_mag));
    end
  end
  assign rot_ok_c = have_r && prev_present && (rot_sat != '0);
  assign rot_fin  = rot_ok_c ? rot_sat : '0;
  always_comb begin
    if (!rot_ok_c) begin
      run_nxt = '0;
    end else if (run_q < RUN_MAX) begin
      run_nxt = run_q + RUN_W'(1);
    end else begin
      run_nxt = run_q;
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_CALC: begin
        case (step_r)
          4'd0: begin
            mul_a = 34'(pa_r[23:0]);
            mul_b = 34'(wl_a_r);
          end
          4'd1: begin
            mul_a = 34'(hs_a);
            mul_b = 34'(wl_a_r);
          end
          4'd2: begin
            mul_a = 34'(pb_r[23:0]);
            mul_b = 34'(wl_b_r);
          end
          4'd3: begin
            mul_a = 34'(hs_b);
            mul_b = 34'(wl_b_r);
          end
          4'd6: begin
            mul_a = 34'(dmag[28:0]);
            mul_b = 34'(smag);
          end
          4'd7: begin
            mul_a = 34'(dmag[57:29]);
            mul_b = 34'(smag);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      ST_WIN: begin
        mul_a = 34'(x_win);
        mul_b = 34'(x_win);
      end
      ST_TOT: begin
        case (step_r)
          4'd0: begin
            mul_a = 34'(sum_mag[31:0]);
            mul_b = 34'(sum_mag[31:0]);
          end
          4'd1: begin
            mul_a = 34'(acc_sq_r[27:0]);
            mul_b = 34'(n_eff);
          end
          4'd2: begin
            mul_a = 34'(acc_sq_r[55:28]);
            mul_b = 34'(n_eff);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Memory port control.
  always_comb begin
    sm_raddr   = (state_r == ST_IDLE) ? SLOT_AW'(in_sat_slot) : slot_idx;
    sm_we      = 1'b0;
    sm_waddr   = slot_idx;
    comb_wdata = have_r ? comb_r : '0;
    aux_wdata  = {have_r, pos_inc, run_nxt};
    ring_we    = 1'b0;
    ring_waddr = RING_AW'(slot_idx) * RING_AW'(MAX_WINDOW) + RING_AW'(pos_q);
    ring_wdata = rot_fin;
    ring_raddr = RING_AW'(slot_idx) * RING_AW'(MAX_WINDOW) + RING_AW'(rd_dec);
    case (state_r)
      ST_CLEAR: begin
        ring_we    = 1'b1;
        ring_waddr = clr_cnt_r;
        ring_wdata = '0;
        sm_we      = 32'(clr_cnt_r) < MAX_SATS;
        sm_waddr   = SLOT_AW'(clr_cnt_r);
        comb_wdata = '0;
        aux_wdata  = '0;
      end
      ST_CALC: begin
        sm_we   = (step_r == 4'd9);
        ring_we = (step_r == 4'd9);
      end
      default: begin
        sm_we   = 1'b0;
        ring_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (sm_we) begin
      comb_mem[sm_waddr] <= comb_wdata;
      aux_mem[sm_waddr]  <= aux_wdata;
    end
    comb_q_r <= comb_mem[sm_raddr];
    aux_q_r  <= aux_mem[sm_raddr];
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= ring_wdata;
    end
    ring_q_r <= ring_mem[ring_raddr];
  end

  assign sq_req.go      = (state_r == ST_TOT) && (step_r == 4'd5) && roti_ok_r;
  assign sq_req.divisor = DIVISOR_W'(n_eff);

  roti_isqrt_div u_isqrt_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (sq_req),
    .radicand (v_r),
    .stat     (sq_stat),
    .roti     (sq_roti)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      step_r      <= '0;
      e_r         <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      wl_a_r      <= WL_A_RESET;
      wl_b_r      <= WL_B_RESET;
      scale_r     <= ROT_SCALE_RESET;
      wlen_r      <= WLEN_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_WAVELENGTH_A:  wl_a_r  <= cfg_data;
          CFG_WAVELENGTH_B:  wl_b_r  <= cfg_data;
          CFG_ROT_SCALE:     scale_r <= signed'(cfg_data);
          CFG_WINDOW_LENGTH: wlen_r  <= cfg_data[WLEN_W-1:0];
          default:           wlen_r  <= wlen_r;
        endcase
      end

      prod_r <= mul_a * mul_b;
      pend_r <= (state_r == ST_WIN);
      // Squares of the ring walk land in the cycle after their operands.
      if (pend_r) begin
        acc_sq_r <= acc_sq_r + 56'(prod_r[47:0]);
      end
      // In ST_OUT the load below decides the valid flag.
      if (out_valid_r && !out_stall && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + RING_AW'(1);
          if (clr_cnt_r == CLR_LAST) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            slot_r <= in_sat_slot;
            pa_r   <= in_phase_a;
            pb_r   <= in_phase_b;
            have_r <= (in_phase_a != '0) && (in_phase_b != '0);
            step_r <= '0;
            if (in_range) begin
              state_r <= ST_CALC;
            end else begin
              rot_r     <= '0;
              rot_ok_r  <= 1'b0;
              roti_r    <= '0;
              roti_ok_r <= 1'b0;
              state_r   <= ST_OUT;
            end
          end
        end
        ST_CALC: begin
          step_r <= step_r + 4'd1;
          case (step_r)
            4'd1: comb_r <= signed'({32'd0, prod_r[55:24]});
            4'd2: comb_r <= comb_r + prod_r[63:0];
            4'd3: comb_r <= comb_r - signed'({32'd0, prod_r[55:24]});
            4'd4: comb_r <= comb_r - prod_r[63:0];
            4'd5: diff_r <= comb_r - comb_q_r;
            4'd7: sp_r   <= 96'(prod_r[60:0]);
            4'd8: sp_r   <= sp_r + (96'(prod_r[60:0]) << 29);
            4'd9: begin
              rot_r     <= rot_fin;
              rot_ok_r  <= rot_ok_c;
              roti_ok_r <= run_nxt >= n_eff;
              rd_idx_r  <= pos_q;
              acc_sum_r <= '0;
              acc_sq_r  <= '0;
              e_r       <= '0;
              state_r   <= ST_WIN;
            end
            default: ;
          endcase
        end
        ST_WIN: begin
          acc_sum_r <= acc_sum_r + 33'(x_win);
          rd_idx_r  <= rd_dec;
          e_r       <= e_r + RUN_W'(1);
          if (e_r == n_eff - RUN_W'(1)) begin
            step_r  <= '0;
            state_r <= ST_TOT;
          end
        end
        ST_TOT: begin
          step_r <= step_r + 4'd1;
          case (step_r)
            4'd1: sq2_r <= prod_r[63:0];
            4'd2: tot_r <= prod_r[63:0];
            4'd3: tot_r <= tot_r + (prod_r[63:0] << 28);
            4'd4: v_r   <= (tot_r >= sq2_r) ? tot_r - sq2_r : '0;
            4'd5: begin
              if (roti_ok_r) begin
                state_r <= ST_SQ;
              end else begin
                roti_r  <= '0;
                state_r <= ST_OUT;
              end
            end
            default: ;
          endcase
        end
        ST_SQ: begin
          if (sq_stat.done) begin
            roti_r  <= sq_roti;
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r   <= 1'b1;
            out_slot_r    <= slot_r;
            out_rot_r     <= rot_r;
            out_rot_ok_r  <= rot_ok_r;
            out_roti_r    <= roti_r;
            out_roti_ok_r <= roti_ok_r;
            state_r       <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_slot_echo  = out_slot_r;
  assign out_rot_value  = out_rot_r;
  assign out_rot_ok     = out_rot_ok_r;
  assign out_roti_value = out_roti_r;
  assign out_roti_ok    = out_roti_ok_r;

  `ROTI_ASSERT_IMPL(a_roti_needs_rot, out_valid && out_roti_ok, out_rot_ok, "ROTI without ROT")
  `ROTI_ASSERT_IMPL(a_rot_zero_when_missing, out_valid && !out_rot_ok, out_rot_value == '0, "ROT not zeroed")
  `ROTI_ASSERT_IMPL(a_root_start_idle, sq_req.go, !sq_stat.busy, "root unit started while busy")
  `ROTI_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_r != ST_IDLE, "item accepted but idle")

endmodule

[tb/roti_sliding_index_checker.sv]
// ----------------------------------------------------------------------------
// ROTI sliding index checker
// Watches the configuration port and both channels of the unit, predicts the
// result of each accepted item from its own copy of the per-slot state and
// compares it field by field with what the unit delivers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module roti_sliding_index_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [roti_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [roti_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [roti_pkg::SLOT_W-1:0]         in_sat_slot,
  input  logic signed [roti_pkg::PHASE_W-1:0] in_phase_a,
  input  logic signed [roti_pkg::PHASE_W-1:0] in_phase_b,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [roti_pkg::SLOT_W-1:0]         out_slot_echo,
  input  logic signed [roti_pkg::ROT_W-1:0]   out_rot_value,
  input  logic                                out_rot_ok,
  input  logic [roti_pkg::ROTI_W-1:0]         out_roti_value,
  input  logic                                out_roti_ok,
  output int                                  errors,
  output int                                  pending,
  output int                                  rot_count,
  output int                                  roti_count
);
  import roti_pkg::*;

  typedef struct {
    logic [SLOT_W-1:0]        slot;
    logic signed [ROT_W-1:0]  rot;
    logic                     rot_ok;
    logic [ROTI_W-1:0]        roti;
    logic                     roti_ok;
  } epoch_result_t;

  epoch_result_t     awaited_epochs[$];

  logic [CFG_W-1:0]        wl_a;
  logic [CFG_W-1:0]        wl_b;
  logic signed [CFG_W-1:0] rate_scale;
  logic [WLEN_W-1:0]       wlen;

  logic signed [63:0]      last_comb[64];
  bit                      last_have[64];
  logic signed [ROT_W-1:0] rot_hist[64][32];
  int                      hist_pos[64];
  int                      good_run[64];

  function automatic logic signed [63:0] band_product(logic signed [PHASE_W-1:0] ph,
                                                      logic [CFG_W-1:0] wl);
    logic signed [81:0] p;
    p = ph * $signed({1'b0, wl});
    return p >>> 24;
  endfunction

  // Rounds the magnitude half away from zero, then applies the sign and clamps.
  function automatic logic signed [ROT_W-1:0] tec_rate(logic signed [63:0] d,
                                                      logic signed [CFG_W-1:0] sc);
    logic [63:0]  md;
    logic [31:0]  msc;
    logic [127:0] m;
    bit           neg;
    neg = (d < 0) != (sc < 0);
    md  = (d < 0) ? -d : d;
    msc = (sc < 0) ? -sc : sc;
    m   = ({64'd0, md} * {96'd0, msc} + (128'd1 << 27)) >> 28;
    if (neg) return (m >= 128'd8388608) ? -24'sd8388608 : -$signed(m[23:0]);
    return (m >= 128'd8388607) ? 24'sd8388607 : $signed(m[23:0]);
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic epoch_result_t predict_epoch(logic [SLOT_W-1:0] s,
                                                  logic signed [PHASE_W-1:0] pa,
                                                  logic signed [PHASE_W-1:0] pb);
    epoch_result_t      e;
    logic signed [63:0] comb;
    logic signed [ROT_W-1:0] rot;
    int                 n;
    int                 pos;
    longint             acc;
    logic [63:0]        acc_sq;
    logic [63:0]        mx;
    logic [63:0]        ms;
    logic [63:0]        total;
    logic [63:0]        v;
    logic [63:0]        r;
    n = (wlen < 2) ? 2 : (wlen > 32) ? 32 : int'(wlen);
    rot = 0;
    e.slot = s;
    e.rot_ok = 0;
    e.roti_ok = 0;
    e.roti = 0;
    if (pa != 0 && pb != 0) begin
      comb = band_product(pa, wl_a) - band_product(pb, wl_b);
      if (last_have[s]) begin
        rot = tec_rate(comb - last_comb[s], rate_scale);
        e.rot_ok = (rot != 0);
      end
      last_comb[s] = comb;
      last_have[s] = 1;
    end else begin
      last_comb[s] = 0;
      last_have[s] = 0;
    end
    pos = hist_pos[s];
    rot_hist[s][pos] = rot;
    hist_pos[s] = (pos + 1) % 32;
    if (e.rot_ok) begin
      if (good_run[s] < 32) good_run[s]++;
    end else begin
      good_run[s] = 0;
    end
    acc = 0;
    acc_sq = 0;
    for (int i = 0; i < n; i++) begin
      acc += longint'(rot_hist[s][(pos + 32 - i) % 32]);
      mx = (rot_hist[s][(pos + 32 - i) % 32] < 0) ?
           64'(-longint'(rot_hist[s][(pos + 32 - i) % 32])) :
           64'(rot_hist[s][(pos + 32 - i) % 32]);
      acc_sq += mx * mx;
    end
    if (good_run[s] >= n) begin
      total = 64'(n) * acc_sq;
      ms = (acc < 0) ? 64'(-acc) : 64'(acc);
      v = (total >= ms * ms) ? total - ms * ms : 0;
      r = root_floor(v) / n;
      e.roti = (r > 64'(ROTI_CAP)) ? ROTI_CAP : r[ROTI_W-1:0];
      e.roti_ok = 1;
    end
    e.rot = e.rot_ok ? rot : '0;
    return e;
  endfunction

  always @(posedge clk) begin
    epoch_result_t want;
    if (!rst_n) begin
      wl_a = WL_A_RESET;
      wl_b = WL_B_RESET;
      rate_scale = ROT_SCALE_RESET;
      wlen = WLEN_RESET;
      for (int s = 0; s < 64; s++) begin
        last_comb[s] = 0;
        last_have[s] = 0;
        hist_pos[s] = 0;
        good_run[s] = 0;
        for (int k = 0; k < 32; k++) rot_hist[s][k] = 0;
      end
      awaited_epochs.delete();
      errors = 0;
      rot_count = 0;
      roti_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_WAVELENGTH_A:  wl_a = cfg_data;
          CFG_WAVELENGTH_B:  wl_b = cfg_data;
          CFG_ROT_SCALE:     rate_scale = cfg_data;
          CFG_WINDOW_LENGTH: wlen = cfg_data[WLEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        awaited_epochs.push_back(predict_epoch(in_sat_slot, in_phase_a, in_phase_b));
      if (out_valid && !out_stall) begin
        if (awaited_epochs.size() == 0) begin
          $display("%0t: result for slot %0d arrived with none expected", $time,
                   out_slot_echo);
          errors++;
        end else begin
          want = awaited_epochs.pop_front();
          if (out_rot_ok) rot_count++;
          if (out_roti_ok) roti_count++;
          if (out_slot_echo !== want.slot || out_rot_value !== want.rot ||
              out_rot_ok !== want.rot_ok || out_roti_value !== want.roti ||
              out_roti_ok !== want.roti_ok) begin
            $display("%0t: mismatch expected slot %0d rot %0d/%0b roti %0d/%0b",
                     $time, want.slot, want.rot, want.rot_ok, want.roti, want.roti_ok);
            $display("%0t:          actual   slot %0d rot %0d/%0b roti %0d/%0b",
                     $time, out_slot_echo, out_rot_value, out_rot_ok, out_roti_value,
                     out_roti_ok);
            errors++;
          end
        end
      end
    end
    pending = awaited_epochs.size();
  end

endmodule

[tb/roti_sliding_index_unit_test.sv]
// ----------------------------------------------------------------------------
// ROTI sliding index unit testbench
// Drives satellite epochs through the unit under several register settings
// and idle patterns, mostly as continuous per-slot phase tracks so that the
// ROT windows fill, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module roti_sliding_index_unit_test;
  import roti_pkg::*;

  localparam int STALL_LIMIT = 6000;

  logic                          clk = 0;
  logic                          rst_n = 0;
  logic                          cfg_we = 0;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_W-1:0]              cfg_data = '0;
  logic                          in_valid = 0;
  logic                          in_stall;
  logic [SLOT_W-1:0]             in_sat_slot = '0;
  logic signed [PHASE_W-1:0]     in_phase_a = '0;
  logic signed [PHASE_W-1:0]     in_phase_b = '0;
  logic                          out_valid;
  logic                          out_stall = 0;
  logic [SLOT_W-1:0]             out_slot_echo;
  logic signed [ROT_W-1:0]       out_rot_value;
  logic                          out_rot_ok;
  logic [ROTI_W-1:0]             out_roti_value;
  logic                          out_roti_ok;

  int errors, pending, rot_count, roti_count;
  int send_idle_pct = 29;
  int recv_idle_pct = 45;
  int items_sent = 0;
  int quiet_cycles = 0;
  int run_cycle = 0;
  logic signed [PHASE_W-1:0] track_a[64];
  logic signed [PHASE_W-1:0] track_b[64];

  always #1 clk = ~clk;

  roti_sliding_index_unit i_dut (.*);

  roti_sliding_index_checker i_checker (.*);

  // The receiver holds off for a long stretch once, well after the clearing pass.
  always @(posedge clk) begin
    run_cycle <= run_cycle + 1;
    if (run_cycle >= 3000 && run_cycle < 3500)
      out_stall <= 1;
    else
      out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout after %0d cycles without progress", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_epoch(logic [SLOT_W-1:0] s, logic signed [PHASE_W-1:0] pa,
                            logic signed [PHASE_W-1:0] pb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_sat_slot <= s;
    in_phase_a <= pa;
    in_phase_b <= pb;
    do @(posedge clk); while (!(in_valid && !in_stall));
    items_sent++;
  endtask

  function automatic logic signed [PHASE_W-1:0] phase_step();
    logic signed [PHASE_W-1:0] d;
    d = PHASE_W'(64'd1 << $urandom_range(0, 30)) + PHASE_W'($urandom_range(0, 255));
    return $urandom_range(1) ? d : -d;
  endfunction

  task automatic send_random_epoch();
    logic [SLOT_W-1:0]         s;
    logic signed [PHASE_W-1:0] pa;
    logic signed [PHASE_W-1:0] pb;
    if ($urandom_range(99) < 80) begin
      // Tracked slot: small steps keep the ROT in range and the windows filling.
      s = ($urandom_range(9) == 0) ? SLOT_W'($urandom_range(63)) : SLOT_W'($urandom_range(11));
      track_a[s] = track_a[s] + phase_step();
      track_b[s] = track_b[s] + phase_step();
      if (track_a[s] == 0) track_a[s] = 1;
      if (track_b[s] == 0) track_b[s] = 1;
      pa = track_a[s];
      pb = track_b[s];
      if ($urandom_range(99) < 4) pa = 0;
      if ($urandom_range(99) < 4) pb = 0;
    end else begin
      s = SLOT_W'($urandom_range(63));
      pa = PHASE_W'({$urandom, $urandom});
      pb = PHASE_W'({$urandom, $urandom});
      if ($urandom_range(9) == 0) pa = 0;
      if ($urandom_range(9) == 0) pb = 0;
    end
    send_epoch(s, pa, pb);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // Registers change only once every result is back and the unit has settled.
  task automatic settle_and_configure(logic [CFG_W-1:0] wa, logic [CFG_W-1:0] wb,
                                      logic [CFG_W-1:0] sc, logic [CFG_W-1:0] wl);
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    write_reg(CFG_WAVELENGTH_A, wa);
    write_reg(CFG_WAVELENGTH_B, wb);
    write_reg(CFG_ROT_SCALE, sc);
    write_reg(CFG_WINDOW_LENGTH, wl);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  initial begin
    logic signed [PHASE_W-1:0] pmax;
    logic signed [PHASE_W-1:0] pmin;
    pmax = {1'b0, {(PHASE_W-1){1'b1}}};
    pmin = {1'b1, {(PHASE_W-1){1'b0}}};
    for (int s = 0; s < 64; s++) begin
      track_a[s] = PHASE_W'({$urandom, $urandom});
      track_b[s] = PHASE_W'({$urandom, $urandom});
    end
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed epochs under the reset settings: missing phases, a first epoch,
    // saturation both ways, a zero rate and a full window on the top slot.
    send_epoch(0, 0, 48'sd5);
    send_epoch(0, pmax, pmin);
    send_epoch(0, pmin, pmax);
    send_epoch(0, pmax, pmin);
    send_epoch(0, pmax, pmin);
    send_epoch(0, 48'sd7, 0);
    for (int k = 0; k < 13; k++)
      send_epoch(63, 48'sd1000000 + k * 48'sd70000, -48'sd3000000 + k * k * 48'sd9000);
    send_epoch(63, 48'sd1, 0);
    for (int k = 0; k < 320; k++) send_random_epoch();

    settle_and_configure(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'd2);
    for (int k = 0; k < 320; k++) send_random_epoch();

    send_idle_pct = 45;
    recv_idle_pct = 29;
    settle_and_configure($urandom, $urandom, 32'h8000_0000, 32'd32);
    for (int k = 0; k < 320; k++) send_random_epoch();

    settle_and_configure(32'h0, 32'hFFFF_FFFF, $urandom, 32'd63);
    for (int k = 0; k < 160; k++) send_random_epoch();
    settle_and_configure($urandom, $urandom, -$urandom_range(1, 1 << 22), 32'd0);
    for (int k = 0; k < 160; k++) send_random_epoch();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    settle_and_configure(WL_A_RESET, WL_B_RESET, ROT_SCALE_RESET,
                         32'($urandom_range(3, 31)));
    for (int k = 0; k < 320; k++) send_random_epoch();

    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Ran %0d epochs over six register settings and three idle patterns.",
             items_sent);
    $display("Results with a valid ROT: %0d, with a full ROTI window: %0d.",
             rot_count, roti_count);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/roti_pkg.sv
design/roti_isqrt_div.sv
design/roti_sliding_index_unit.sv
tb/roti_sliding_index_checker.sv
tb/roti_sliding_index_unit_test.sv
